// File: rtl/lgu_pkg.sv
// ----------------------------------------------------------------------------
// lgu_pkg: shared types and constants of the loss and gradient unit
// Holds the fixed-point format, the register indexes, the controller state
// and command types, and the natural-log table built at elaboration.
// ----------------------------------------------------------------------------
package lgu_pkg;

	// Fixed-point format and log table geometry
	localparam int FRAC_BITS      = 24;
	localparam int LOG_TABLE_SIZE = 256;
	localparam int LOG_IDX_W      = $clog2(LOG_TABLE_SIZE);
	localparam int LN_W           = 31;
	localparam int EXP_W          = $clog2(FRAC_BITS + 1);
	localparam int LN_MAG_W       = LN_W + EXP_W;

	// Divider geometry: left-aligned dividend, divisor holds den * n
	localparam int DIV_N_W   = 64;
	localparam int DIV_D_W   = FRAC_BITS + 16;
	localparam int DIV_LEN_W = $clog2(DIV_N_W + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 4'd1;

	typedef logic [LN_W-1:0] ln_table_t [0:LOG_TABLE_SIZE];

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL1,
		ST_MUL2,
		ST_DIV_G,
		ST_WAIT_G,
		ST_GRAD,
		ST_LN_A,
		ST_LN_B,
		ST_LN_C,
		ST_MF1,
		ST_MF2,
		ST_ACC,
		ST_DIV_M,
		ST_WAIT_M,
		ST_MEAN,
		ST_OUT
	} lgu_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP,
		OP_MUL1,
		OP_MUL2,
		OP_DIV_GRAD,
		OP_GRAD,
		OP_LN_A,
		OP_LN_B,
		OP_LN_C,
		OP_MF1,
		OP_MF2,
		OP_ACC,
		OP_DIV_MEAN,
		OP_MEAN,
		OP_OUT
	} lgu_op_t;

	typedef struct packed {
		lgu_op_t op;
		logic    ln_sel;   // 0: log of p, 1: log of 1-p
	} lgu_cmd_t;

	typedef struct packed {
		logic mode;        // latched loss mode of the current word
		logic last;        // current word closes the tensor
		logic div_done;    // divider quotient ready
		logic out_free;    // output register can take a word
	} lgu_stat_t;

	// Long division by shift and subtract, used only at elaboration
	function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// ln(1 + i/SIZE) in Q30 through 2*atanh((m-1)/(m+1))
	function automatic ln_table_t build_ln_table();
		ln_table_t tbl;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] pw;
		logic [63:0] s;
		for (int i = 0; i <= LOG_TABLE_SIZE; i++) begin
			z  = udiv64(64'(i) << 30, 64'(2 * LOG_TABLE_SIZE + i));
			z2 = (z * z) >> 30;
			pw = z;
			s  = z;
			for (int k = 1; k <= 24; k++) begin
				pw = (pw * z2) >> 30;
				s  = s + udiv64(pw, 64'(2 * k + 1));
			end
			tbl[i] = LN_W'(s << 1);
		end
		return tbl;
	endfunction

	localparam ln_table_t LN_TABLE = build_ln_table();

endpackage

// File: rtl/lgu_div.sv
// ----------------------------------------------------------------------------
// lgu_div: unsigned restoring divider
// Takes a left-aligned dividend and a bit count, retires one quotient bit
// per cycle, and pulses done when the quotient is complete.
// ----------------------------------------------------------------------------
module lgu_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lgu_pkg::DIV_N_W-1:0]         dividend,
	input  logic [lgu_pkg::DIV_D_W-1:0]         divisor,
	input  logic [lgu_pkg::DIV_LEN_W-1:0]       len,
	output logic                                busy,
	output logic                                done,
	output logic [lgu_pkg::DIV_N_W-1:0]         quotient
);
	import lgu_pkg::*;

	logic [DIV_N_W-1:0]   num_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_D_W:0]     rem_q;
	logic [DIV_LEN_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W:0]     rem_sh;
	logic [DIV_D_W:0]     rem_nx;
	logic                 fits;

	// One restoring step: shift in next dividend bit, subtract if it fits
	assign rem_sh = {rem_q[DIV_D_W-1:0], num_q[DIV_N_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_N_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/lgu_datapath.sv
// ----------------------------------------------------------------------------
// lgu_datapath: arithmetic of the loss and gradient unit
// Holds the configuration, the running loss sum and element index, the
// multipliers, the log interpolation, the divider and the output register.
// Each cycle it performs the step named by the controller command.
// ----------------------------------------------------------------------------
module lgu_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lgu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lgu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [31:0]                 prediction,
	input  logic signed [31:0]                 target,
	input  lgu_pkg::lgu_cmd_t                  cmd,
	output lgu_pkg::lgu_stat_t                 stat,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [31:0]                 gradient,
	output logic [30:0]                        mean_loss,
	output logic                               last
);
	import lgu_pkg::*;

	localparam int PW  = FRAC_BITS;
	localparam int PHW = 34 + LN_MAG_W - FRAC_BITS;
	localparam int PLW = 34 + FRAC_BITS;
	localparam logic signed [33:0] One   = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [33:0] EpsLo = 34'sd2;
	localparam logic signed [33:0] EpsHi = One - 34'sd2;
	localparam logic [DIV_LEN_W-1:0] LenMse  = DIV_LEN_W'(33);
	localparam logic [DIV_LEN_W-1:0] LenBce  = DIV_LEN_W'(32 + FRAC_BITS);
	localparam logic [DIV_LEN_W-1:0] LenMean = DIV_LEN_W'(63);
	localparam logic signed [63:0] SumMax = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] SumMin = {1'b1, {63{1'b0}}};

	// Configuration and state
	logic                     mode_cfg_q;
	logic [15:0]              count_cfg_q;
	logic signed [63:0]       sum_q;
	logic [15:0]              idx_q;
	logic                     last_q;
	logic                     out_valid_q;

	// Word payload
	logic                     mode_q;
	logic [15:0]              n_q;
	logic signed [31:0]       p_q;
	logic signed [31:0]       t_q;
	logic signed [33:0]       diff_q;
	logic [PW-1:0]            pc_q;
	logic [PW-1:0]            qc_q;
	logic [63:0]              prod_q;
	logic [DIV_D_W-1:0]       den_q;
	logic signed [31:0]       grad_q;
	logic [30:0]              mean_q;
	logic signed [63:0]       term_q;
	logic [29:0]              f30_q;
	logic [EXP_W-1:0]         b_q;
	logic [LN_W-1:0]          lo_q;
	logic [LN_W-1:0]          interp_q;
	logic [LN_MAG_W-1:0]      l_q;
	logic [PHW-1:0]           phi_q;
	logic [PLW-1:0]           plo_q;
	logic                     aneg_q;
	logic signed [31:0]       out_grad_q;
	logic [30:0]              out_mean_q;
	logic                     out_last_q;

	// Combinational terms
	logic signed [33:0]       p_ext;
	logic signed [33:0]       t_ext;
	logic signed [33:0]       pcl_w;
	logic signed [33:0]       qcl_w;
	logic signed [33:0]       diff_w;
	logic [31:0]              dmag_w;
	logic [2*PW-1:0]          pq_w;
	logic [63:0]              sq_w;
	logic [PW-1:0]            dd_w;
	logic [PW-1:0]            dd1_w;
	logic [DIV_D_W-1:0]       bden_w;
	logic [63:0]              quot_w;
	logic signed [31:0]       gsat_w;
	logic [PW-1:0]            x_w;
	logic [EXP_W-1:0]         b_w;
	logic [30:0]              xs_w;
	logic [LOG_IDX_W-1:0]     tidx_w;
	logic [LOG_IDX_W:0]       tidx1_w;
	logic [29:0]              frac_w;
	logic [LN_W-1:0]          tlo_w;
	logic [LN_W-1:0]          thi_w;
	logic [LN_W-1:0]          step_w;
	logic [LN_W+29:0]         ip_w;
	logic [LN_W:0]            lnm_w;
	logic [EXP_W-1:0]         e_w;
	logic [LN_MAG_W-1:0]      mag_w;
	logic [LN_MAG_W-1:0]      nl_w;
	logic signed [33:0]       a_w;
	logic [33:0]              amag_w;
	logic [63:0]              r_w;
	logic signed [63:0]       sum_add_w;
	logic signed [63:0]       sum_nx_w;
	logic [15:0]              idx1_w;
	logic                     last_w;
	logic                     div_start;
	logic [DIV_N_W-1:0]       div_num;
	logic [DIV_D_W-1:0]       div_den;
	logic [DIV_LEN_W-1:0]     div_len;
	logic                     div_busy;
	logic                     div_done;
	logic [DIV_N_W-1:0]       div_quot;

	// Clamp, difference and magnitude
	always_comb begin
		p_ext = 34'(p_q);
		t_ext = 34'(t_q);
		if (p_ext < EpsLo) begin
			pcl_w = EpsLo;
		end else if (p_ext > EpsHi) begin
			pcl_w = EpsHi;
		end else begin
			pcl_w = p_ext;
		end
		qcl_w  = One - pcl_w;
		diff_w = (mode_q ? pcl_w : p_ext) - t_ext;
		dmag_w = diff_q[33] ? 32'(34'sd0 - diff_q) : 32'(diff_q);
	end

	// Products and BCE denominator
	always_comb begin
		pq_w   = pc_q * qc_q;
		sq_w   = dmag_w * dmag_w;
		dd_w   = prod_q[2*PW-1:PW];
		dd1_w  = (dd_w == '0) ? PW'(1) : dd_w;
		bden_w = dd1_w * n_q;
	end

	// Gradient saturation: truncated quotient with the sign of p - t
	always_comb begin
		quot_w = div_quot;
		if (diff_q[33]) begin
			gsat_w = (quot_w > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - quot_w);
		end else begin
			gsat_w = (quot_w > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quot_w);
		end
	end

	// Log step A: leading one and normalized mantissa
	always_comb begin
		x_w = cmd.ln_sel ? qc_q : pc_q;
		b_w = '0;
		for (int i = 1; i < PW; i++) begin
			if (x_w[i]) begin
				b_w = EXP_W'(i);
			end
		end
		xs_w = 31'(x_w) << (30 - int'(b_w));
	end

	// Log step B: table lookup and interpolation weight
	always_comb begin
		tidx_w  = f30_q[29 -: LOG_IDX_W];
		tidx1_w = {1'b0, tidx_w} + 1'b1;
		frac_w  = {f30_q[29-LOG_IDX_W:0], {LOG_IDX_W{1'b0}}};
		tlo_w   = LN_TABLE[{1'b0, tidx_w}];
		thi_w   = LN_TABLE[tidx1_w];
		step_w  = (thi_w > tlo_w) ? thi_w - tlo_w : '0;
		ip_w    = step_w * frac_w;
	end

	// Log step C: exponent times ln2 minus mantissa log
	always_comb begin
		lnm_w = {1'b0, lo_q} + {1'b0, interp_q};
		e_w   = EXP_W'(FRAC_BITS) - b_q;
		mag_w = e_w * LN_TABLE[LOG_TABLE_SIZE];
		nl_w  = (mag_w > LN_MAG_W'(lnm_w)) ? mag_w - LN_MAG_W'(lnm_w) : '0;
	end

	// Fractional product of a weight and a log value
	always_comb begin
		a_w    = cmd.ln_sel ? One - t_ext : t_ext;
		amag_w = a_w[33] ? 34'(34'sd0 - a_w) : 34'(a_w);
		r_w    = 64'(phi_q) + 64'(plo_q >> FRAC_BITS);
	end

	// Saturating accumulate and tensor boundary
	always_comb begin
		sum_add_w = sum_q + term_q;
		if ((sum_q[63] == term_q[63]) && (sum_add_w[63] != sum_q[63])) begin
			sum_nx_w = term_q[63] ? SumMin : SumMax;
		end else begin
			sum_nx_w = sum_add_w;
		end
		idx1_w = idx_q + 16'd1;
		last_w = (idx1_w >= n_q) || (idx1_w == 16'd0);
	end

	// Divider operand selection
	always_comb begin
		div_start = (cmd.op == OP_DIV_GRAD) || (cmd.op == OP_DIV_MEAN);
		if (cmd.op == OP_DIV_MEAN) begin
			div_num = (sum_q > 64'sd0) ? {sum_q[62:0], 1'b0} : '0;
			div_den = DIV_D_W'(n_q);
			div_len = LenMean;
		end else begin
			div_num = {dmag_w, 32'd0};
			div_den = den_q;
			div_len = mode_q ? LenBce : LenMse;
		end
	end

	lgu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.len      (div_len),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Configuration, running state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cfg_q  <= 1'b0;
			count_cfg_q <= 16'd1;
			sum_q       <= '0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOSS_MODE:     mode_cfg_q  <= cfg_data[0];
					REG_ELEMENT_COUNT: count_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_ACC) begin
				sum_q  <= sum_nx_w;
				idx_q  <= last_w ? 16'd0 : idx1_w;
				last_q <= last_w;
			end else if (cmd.op == OP_DIV_MEAN) begin
				sum_q <= '0;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-word datapath steps
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				p_q    <= prediction;
				t_q    <= target;
				mode_q <= mode_cfg_q;
				n_q    <= (count_cfg_q == 16'd0) ? 16'd1 : count_cfg_q;
			end
			OP_PREP: begin
				diff_q <= diff_w;
				pc_q   <= pcl_w[PW-1:0];
				qc_q   <= qcl_w[PW-1:0];
				term_q <= '0;
			end
			OP_MUL1: begin
				prod_q <= mode_q ? 64'(pq_w) : sq_w;
			end
			OP_MUL2: begin
				den_q <= mode_q ? bden_w : DIV_D_W'(n_q);
				if (!mode_q) begin
					term_q <= $signed(prod_q >> FRAC_BITS);
				end
			end
			OP_GRAD: begin
				grad_q <= gsat_w;
			end
			OP_LN_A: begin
				f30_q <= xs_w[29:0];
				b_q   <= b_w;
			end
			OP_LN_B: begin
				lo_q     <= tlo_w;
				interp_q <= ip_w[LN_W+29:30];
			end
			OP_LN_C: begin
				l_q <= nl_w >> (30 - FRAC_BITS);
			end
			OP_MF1: begin
				phi_q  <= amag_w * l_q[LN_MAG_W-1:FRAC_BITS];
				plo_q  <= amag_w * l_q[FRAC_BITS-1:0];
				aneg_q <= a_w[33];
			end
			OP_MF2: begin
				term_q <= term_q + (aneg_q ? $signed(64'd0 - r_w) : $signed(r_w));
			end
			OP_ACC: begin
				mean_q <= '0;
			end
			OP_MEAN: begin
				mean_q <= (div_quot > 64'h7FFF_FFFF) ? '1 : div_quot[30:0];
			end
			OP_OUT: begin
				out_grad_q <= grad_q;
				out_mean_q <= mean_q;
				out_last_q <= last_q;
			end
			default: ;
		endcase
	end

	assign stat.mode     = mode_q;
	assign stat.last     = last_q;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign gradient  = out_grad_q;
	assign mean_loss = out_mean_q;
	assign last      = out_last_q;

	// A word that does not close a tensor carries no mean
	a_mean_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_mean_q == '0)
		else $error("mean_loss nonzero on a word without last");

	// Never overwrite a result that is still waiting
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> (!out_valid_q || out_ready))
		else $error("output register loaded while occupied");

	// The divider is started only when idle
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

// File: rtl/lgu_ctrl.sv
// ----------------------------------------------------------------------------
// lgu_ctrl: sequencer of the loss and gradient unit
// Accepts one input word at a time and walks the datapath through the
// gradient division, the two log passes of cross-entropy, the accumulate,
// the mean division at the end of a tensor, and the output load.
// ----------------------------------------------------------------------------
module lgu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lgu_pkg::lgu_stat_t    stat,
	output lgu_pkg::lgu_cmd_t     cmd
);
	import lgu_pkg::*;

	lgu_state_t state_q;
	lgu_state_t state_nx;
	logic       sel_q;
	logic       sel_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			sel_q   <= sel_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx   = state_q;
		sel_nx     = sel_q;
		in_ready   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.ln_sel = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.op   = OP_PREP;
				state_nx = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.op   = OP_MUL1;
				state_nx = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.op   = OP_MUL2;
				state_nx = ST_DIV_G;
			end
			ST_DIV_G: begin
				cmd.op   = OP_DIV_GRAD;
				state_nx = ST_WAIT_G;
			end
			ST_WAIT_G: begin
				if (stat.div_done) begin
					state_nx = ST_GRAD;
				end
			end
			ST_GRAD: begin
				cmd.op   = OP_GRAD;
				sel_nx   = 1'b0;
				state_nx = stat.mode ? ST_LN_A : ST_ACC;
			end
			ST_LN_A: begin
				cmd.op   = OP_LN_A;
				state_nx = ST_LN_B;
			end
			ST_LN_B: begin
				cmd.op   = OP_LN_B;
				state_nx = ST_LN_C;
			end
			ST_LN_C: begin
				cmd.op   = OP_LN_C;
				state_nx = ST_MF1;
			end
			ST_MF1: begin
				cmd.op   = OP_MF1;
				state_nx = ST_MF2;
			end
			ST_MF2: begin
				// second pass covers 1-p, then accumulate
				cmd.op = OP_MF2;
				if (sel_q) begin
					state_nx = ST_ACC;
				end else begin
					sel_nx   = 1'b1;
					state_nx = ST_LN_A;
				end
			end
			ST_ACC: begin
				cmd.op   = OP_ACC;
				state_nx = ST_DIV_M;
			end
			ST_DIV_M: begin
				if (stat.last) begin
					cmd.op   = OP_DIV_MEAN;
					state_nx = ST_WAIT_M;
				end else begin
					state_nx = ST_OUT;
				end
			end
			ST_WAIT_M: begin
				if (stat.div_done) begin
					state_nx = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.op   = OP_MEAN;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.op   = OP_OUT;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/loss_and_gradient_unit_core.sv
// ----------------------------------------------------------------------------
// loss_and_gradient_unit_core: MSE / binary cross-entropy loss and gradient
// Streams prediction/target pairs in Q8.24 and returns the per-element
// gradient, with the mean loss and last on the n-th element of a tensor.
// ----------------------------------------------------------------------------
// One word is in flight at a time. Mean squared error and cross-entropy
// words both pass through the shared one-bit-per-cycle divider (33
// quotient bits for MSE, 56 for BCE), and a cross-entropy word also
// takes two log/product passes. The word that closes a tensor adds a
// 63-bit mean division. A finished result waits in an output register,
// so the next input word is taken while it is still pending. s_tdata:
// prediction [31:0], target [63:32]. m_tdata: gradient [31:0], mean_loss
// [62:32], zero [63]; m_tlast marks the last element. Configuration:
// index 0 loss_mode, index 1 element_count (0 acts as 1); writes are
// accepted in every cycle.
// ----------------------------------------------------------------------------
module loss_and_gradient_unit_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lgu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lgu_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [63:0]                        s_tdata,   // prediction, target
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [63:0]                        m_tdata,   // gradient, mean_loss, pad
	output logic                               m_tlast
);
	import lgu_pkg::*;

	lgu_cmd_t           cmd;
	lgu_stat_t          stat;
	logic               in_ready;
	logic signed [31:0] gradient;
	logic [30:0]        mean_loss;

	assign cfg_ready = 1'b1;
	assign s_tready  = in_ready;

	lgu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lgu_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.prediction (s_tdata[31:0]),
		.target     (s_tdata[63:32]),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.gradient   (gradient),
		.mean_loss  (mean_loss),
		.last       (m_tlast)
	);

	// Pack result word
	assign m_tdata = {1'b0, mean_loss, gradient};

endmodule

// File: verif/loss_and_gradient_unit_core_tb.sv
// ----------------------------------------------------------------------------
// loss_and_gradient_unit_core_tb: self-checking bench of the loss unit
// Streams prediction/target words under both loss modes and many element
// counts, predicts gradient, mean loss and last per word in the bench, and
// compares every output word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module loss_and_gradient_unit_core_tb;
	import lgu_pkg::*;

	localparam longint ONE_FX = longint'(1) << FRAC_BITS;
	localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint S64_MIN = -S64_MAX - 1;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -S32_MAX - 1;
	localparam int MODE_MSE = 0;
	localparam int MODE_BCE = 1;

	typedef struct {
		logic [31:0] gradient;
		logic [30:0] mean_loss;
		logic        last;
	} loss_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [63:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [63:0]           m_tdata;
	logic                  m_tlast;

	// shadow of the unit: registers, running sum and element position
	bit [63:0]    ln_q30 [0:LOG_TABLE_SIZE];
	bit           shadow_mode;
	bit [15:0]    shadow_count;
	longint       shadow_sum;
	bit [15:0]    shadow_index;
	loss_result_t pending_results [$];

	int error_count;
	int words_sent;
	int words_checked;
	int tensors_closed;
	int send_idle_pct;
	int recv_idle_pct;

	loss_and_gradient_unit_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ln(1 + i/SIZE) in Q30 from the atanh series
	function automatic void fill_ln_table();
		bit [63:0] z, z2, pw, s;
		for (int i = 0; i <= LOG_TABLE_SIZE; i++) begin
			z  = (64'(i) << 30) / 64'(2 * LOG_TABLE_SIZE + i);
			z2 = (z * z) >> 30;
			pw = z;
			s  = z;
			for (int k = 1; k <= 24; k++) begin
				pw = (pw * z2) >> 30;
				s  = s + pw / 64'(2 * k + 1);
			end
			ln_q30[i] = s << 1;
		end
	endfunction

	// -ln(x) in fixed point: exponent times ln2 minus interpolated mantissa log
	function automatic bit [63:0] minus_ln(bit [63:0] x);
		int        b;
		bit [63:0] f30, pos, idx, frac, lo, hi, lnm, mag;
		b = FRAC_BITS - 1;
		while (b > 0 && x[b] == 1'b0)
			b--;
		f30  = (x - (64'd1 << b)) << (30 - b);
		pos  = f30 * 64'(LOG_TABLE_SIZE);
		idx  = pos >> 30;
		if (idx >= 64'(LOG_TABLE_SIZE))
			idx = 64'(LOG_TABLE_SIZE - 1);
		frac = pos & ((64'd1 << 30) - 1);
		lo   = ln_q30[idx];
		hi   = ln_q30[idx + 1];
		lnm  = lo + ((hi > lo) ? (((hi - lo) * frac) >> 30) : 64'd0);
		mag  = 64'(FRAC_BITS - b) * ln_q30[LOG_TABLE_SIZE];
		mag  = (mag > lnm) ? mag - lnm : 64'd0;
		return mag >> (30 - FRAC_BITS);
	endfunction

	// a * l / 2^FRAC_BITS, truncated toward zero
	function automatic longint scale_by_log(longint a, bit [63:0] l);
		bit [63:0] mag, hi, lo, r;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		hi  = l >> FRAC_BITS;
		lo  = l & ((64'd1 << FRAC_BITS) - 1);
		r   = mag * hi + ((mag * lo) >> FRAC_BITS);
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clip_add(longint a, longint b);
		if (b > 0 && a > S64_MAX - b)
			return S64_MAX;
		if (b < 0 && a < S64_MIN - b)
			return S64_MIN;
		return a + b;
	endfunction

	// advance the shadow by one word and queue the output it must produce
	function automatic void predict_word(logic signed [31:0] pred, logic signed [31:0] targ);
		longint       p, t, n, diff, grad, term, q, m;
		bit [63:0]    mag, den, quot;
		loss_result_t r;
		p = longint'(pred);
		t = longint'(targ);
		n = (shadow_count == 16'd0) ? 1 : longint'(shadow_count);
		if (shadow_mode == MODE_MSE) begin
			diff = p - t;
			mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
			grad = (2 * diff) / n;
			if (grad > S32_MAX)
				grad = S32_MAX;
			if (grad < S32_MIN)
				grad = S32_MIN;
			term = longint'((mag * mag) >> FRAC_BITS);
		end else begin
			// clamp p into [eps, 1-eps] before the divide and the logs
			if (p < 2)
				p = 2;
			if (p > ONE_FX - 2)
				p = ONE_FX - 2;
			q   = ONE_FX - p;
			den = (64'(p) * 64'(q)) >> FRAC_BITS;
			if (den == 0)
				den = 1;
			den  = den * 64'(n);
			diff = p - t;
			mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
			quot = (mag << FRAC_BITS) / den;
			if (diff < 0)
				grad = (quot > 64'd2147483648) ? S32_MIN : -longint'(quot);
			else
				grad = (quot > 64'd2147483647) ? S32_MAX : longint'(quot);
			term = scale_by_log(t, minus_ln(64'(p))) + scale_by_log(ONE_FX - t, minus_ln(64'(q)));
		end
		shadow_sum   = clip_add(shadow_sum, term);
		shadow_index = shadow_index + 16'd1;
		r.gradient   = grad[31:0];
		r.mean_loss  = '0;
		r.last       = 1'b0;
		if (longint'(shadow_index) >= n || shadow_index == 16'd0) begin
			m = (shadow_sum > 0) ? shadow_sum / n : 0;
			if (m > S32_MAX)
				m = S32_MAX;
			r.mean_loss  = m[30:0];
			r.last       = 1'b1;
			shadow_sum   = 0;
			shadow_index = '0;
		end
		pending_results.push_back(r);
	endfunction

	// check each accepted output word against the oldest prediction
	always @(posedge clk) begin
		loss_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("output word with no prediction pending: %h", m_tdata);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				words_checked++;
				if (m_tlast)
					tensors_closed++;
				if (m_tdata[31:0] !== exp_r.gradient) begin
					$error("gradient: expected %h, got %h", exp_r.gradient, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[62:32] !== exp_r.mean_loss) begin
					$error("mean_loss: expected %h, got %h", exp_r.mean_loss, m_tdata[62:32]);
					error_count++;
				end
				if (m_tlast !== exp_r.last) begin
					$error("last: expected %b, got %b", exp_r.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// receiver backpressure
	always @(negedge clk)
		m_tready = ($urandom_range(99) >= recv_idle_pct);

	task automatic send_word(logic signed [31:0] pred, logic signed [31:0] targ);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {targ, pred};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_word(pred, targ);
		words_sent++;
	endtask

	// write one register once everything in flight has drained
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_LOSS_MODE)
			shadow_mode = val[0];
		else if (idx == REG_ELEMENT_COUNT)
			shadow_count = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] fx_in_range();
		case ($urandom_range(5))
			0: return 32'($urandom_range(3));
			1: return 32'(ONE_FX - $urandom_range(3));
			default: return 32'($urandom_range(int'(ONE_FX)));
		endcase
	endfunction

	function automatic logic [31:0] rand_target();
		case ($urandom_range(9))
			0, 1: return 32'(ONE_FX);
			2, 3: return 32'd0;
			4: return 32'($urandom);
			default: return fx_in_range();
		endcase
	endfunction

	function automatic logic [31:0] rand_pred();
		if ($urandom_range(9) < 2)
			return 32'($urandom);
		return fx_in_range();
	endfunction

	function automatic logic [15:0] rand_count();
		case ($urandom_range(19))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(8, 1));
		endcase
	endfunction

	task automatic test_mse_extremes();
		write_reg(REG_LOSS_MODE, 16'(MODE_MSE));
		write_reg(REG_ELEMENT_COUNT, 16'd1);
		send_word(32'h7FFF_FFFF, 32'h8000_0000);
		send_word(32'h8000_0000, 32'h7FFF_FFFF);
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'(ONE_FX), 32'hFFFF_FFFF);
		// zero count acts as one
		write_reg(REG_ELEMENT_COUNT, 16'd0);
		send_word(32'h0123_4567, 32'hFEDC_BA98);
		write_reg(REG_ELEMENT_COUNT, 16'd3);
		send_word(32'h0080_0000, 32'h0100_0000);
		send_word(32'h7FFF_FFFF, 32'h8000_0000);
		send_word(32'hFF00_0000, 32'h0000_0001);
	endtask

	task automatic test_bce_cases();
		write_reg(REG_LOSS_MODE, 16'(MODE_BCE));
		write_reg(REG_ELEMENT_COUNT, 16'd1);
		// clamp at both ends and outside the unit range
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'(ONE_FX), 32'(ONE_FX));
		send_word(32'h8000_0000, 32'(ONE_FX));
		send_word(32'h7FFF_FFFF, 32'h0000_0000);
		send_word(32'h0000_0001, 32'(ONE_FX));
		send_word(32'(ONE_FX / 2), 32'(ONE_FX));
		// targets outside [0,1] on both sides; the negative one gives a negative term
		send_word(32'(ONE_FX / 4), 32'h8000_0000);
		send_word(32'(ONE_FX / 4), 32'h7FFF_FFFF);
		write_reg(REG_ELEMENT_COUNT, 16'hFFFF);
		send_word(32'(ONE_FX / 3), 32'(ONE_FX));
	endtask

	task automatic test_mid_tensor_changes();
		write_reg(REG_ELEMENT_COUNT, 16'd5);
		send_word(32'(ONE_FX / 8), 32'(ONE_FX));
		send_word(32'(ONE_FX / 2), 32'd0);
		// switch mode inside the tensor, then lower the count below the index
		write_reg(REG_LOSS_MODE, 16'(MODE_MSE));
		send_word(32'(ONE_FX), 32'd0);
		write_reg(REG_ELEMENT_COUNT, 16'd2);
		send_word(32'(ONE_FX / 2), 32'(ONE_FX));
	endtask

	task automatic test_random(int items);
		int left;
		int burst;
		left = items;
		while (left > 0) begin
			write_reg(REG_LOSS_MODE, 16'($urandom_range(1)));
			write_reg(REG_ELEMENT_COUNT, rand_count());
			burst = $urandom_range(40, 10);
			for (int i = 0; i < burst && left > 0; i++) begin
				send_word(rand_pred(), rand_target());
				left--;
			end
		end
	endtask

	// hold every input at a known value from time zero
	task automatic clk_init();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		error_count   = 0;
		words_sent    = 0;
		words_checked = 0;
		tensors_closed = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
	endtask

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		clk_init();
		fill_ln_table();
		shadow_mode   = 1'b0;
		shadow_count  = 16'd1;
		shadow_sum    = 0;
		shadow_index  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 51;
		test_mse_extremes();
		test_bce_cases();
		test_mid_tensor_changes();
		test_random(230);
		send_idle_pct = 51;
		recv_idle_pct = 12;
		test_random(230);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(230);

		// drain and let the unit settle
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);

		$display("Covered %0d words in MSE and BCE, %0d tensors closed, %0d words checked",
			words_sent, tensors_closed, words_checked);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
rtl/lgu_pkg.sv
rtl/lgu_div.sv
rtl/lgu_datapath.sv
rtl/lgu_ctrl.sv
rtl/loss_and_gradient_unit_core.sv
verif/loss_and_gradient_unit_core_tb.sv
